@@ src/rds_pkg.sv @@
// ----------------------------------------------------------------------------
// rds_pkg
// Shared types and constants for the RPN digit stack evaluator.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W          = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_UNDER = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_DIVZ  = 3'd3,
    STAT_EMPTY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_DIV
  } bk_state_t;

endpackage

@@ src/rds_ram.sv @@
// ----------------------------------------------------------------------------
// rds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rds_ram #(
  parameter int WIDTH = rds_pkg::DATA_W,
  parameter int DEPTH = rds_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/rds_div.sv @@
// ----------------------------------------------------------------------------
// rds_div
// 32-bit signed divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rds_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic        neg_r;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] rem_nxt;
  logic [31:0] quo_nxt;

  always_comb begin
    mag_a  = dividend[31] ? (32'd0 - dividend) : dividend;
    mag_b  = divisor[31] ? (32'd0 - divisor) : divisor;
    rem_sh = {rem_r, quo_r[31]};
    diff   = rem_sh - {1'b0, dvs_r};
    if (!diff[32]) begin
      rem_nxt = diff[31:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[31:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag_a;
      rem_r <= 32'd0;
      dvs_r <= mag_b;
      neg_r <= dividend[31] ^ divisor[31];
      cnt_r <= 5'd31;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule

@@ src/rds_front.sv @@
// ----------------------------------------------------------------------------
// rds_front
// Accepts characters, classifies them into commands, and queues up to two of them.
// ----------------------------------------------------------------------------
module rds_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char_code,
  input  logic          in_last_char,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output rds_pkg::cmd_t cmd
);

  rds_pkg::cmd_t cls;
  rds_pkg::cmd_t fifo_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          pop;

  always_comb begin
    cls.digit = in_char_code[3:0];
    cls.last  = in_last_char;
    if (in_char_code >= rds_pkg::CH_ZERO && in_char_code <= rds_pkg::CH_NINE) begin
      cls.op = rds_pkg::OP_PUSH;
    end else begin
      unique case (in_char_code)
        rds_pkg::CH_PLUS:  cls.op = rds_pkg::OP_ADD;
        rds_pkg::CH_MINUS: cls.op = rds_pkg::OP_SUB;
        rds_pkg::CH_STAR:  cls.op = rds_pkg::OP_MUL;
        rds_pkg::CH_SLASH: cls.op = rds_pkg::OP_DIV;
        rds_pkg::CH_SPACE: cls.op = rds_pkg::OP_NOP;
        default:           cls.op = rds_pkg::OP_NOP;
      endcase
    end
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= cls;
    end
  end

endmodule

@@ src/rds_back.sv @@
// ----------------------------------------------------------------------------
// rds_back
// Executes commands on the operand stack and registers one result per beat.
// Top of stack lives in a register; entries below it live in the RAM.
// ----------------------------------------------------------------------------
module rds_back #(
  parameter int STACK_DEPTH = rds_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  rds_pkg::cmd_t       cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_top_value,
  output logic [2:0]          out_status,
  output logic                out_done_res
);

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_TWO  = LVL_W'(2);

  rds_pkg::bk_state_t state_r, state_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               err_r, err_nxt;
  logic [31:0]        top_r, top_nxt;
  rds_pkg::op_t       op_r, op_nxt;
  logic               last_r, last_nxt;
  logic               outv_r, outv_nxt;
  logic [31:0]        otop_r, otop_nxt;
  rds_pkg::status_t   ostat_r, ostat_nxt;
  logic               odone_r, odone_nxt;

  logic               take;
  logic               fin;
  logic               fin_last;
  rds_pkg::status_t   fin_stat;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [31:0]        rdata;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_q;

  rds_ram #(
    .WIDTH (rds_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  rds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (top_r),
    .divisor  (rdata),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cmd_ready = (state_r == rds_pkg::BK_IDLE) && (!outv_r || !out_stall);
  assign take      = cmd_valid && cmd_ready;
  assign waddr     = ADDR_W'(level_r - LVL_ONE);
  assign raddr     = ADDR_W'(level_r - LVL_TWO);

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    err_nxt   = err_r;
    top_nxt   = top_r;
    op_nxt    = op_r;
    last_nxt  = last_r;
    outv_nxt  = outv_r && out_stall;
    otop_nxt  = otop_r;
    ostat_nxt = ostat_r;
    odone_nxt = odone_r;
    we        = 1'b0;
    div_start = 1'b0;
    fin       = 1'b0;
    fin_last  = last_r;
    fin_stat  = rds_pkg::STAT_OK;

    unique case (state_r)
      rds_pkg::BK_IDLE: begin
        if (take) begin
          op_nxt   = cmd.op;
          last_nxt = cmd.last;
          fin_last = cmd.last;
          if (err_r) begin
            // character ignored while an error is latched
            fin = 1'b1;
          end else begin
            unique case (cmd.op)
              rds_pkg::OP_PUSH: begin
                fin = 1'b1;
                if (level_r == LVL_FULL) begin
                  fin_stat = rds_pkg::STAT_FULL;
                  err_nxt  = 1'b1;
                end else begin
                  we        = (level_r != '0);
                  top_nxt   = {28'd0, cmd.digit};
                  level_nxt = level_r + LVL_ONE;
                end
              end
              rds_pkg::OP_ADD, rds_pkg::OP_SUB, rds_pkg::OP_MUL, rds_pkg::OP_DIV: begin
                if (level_r < LVL_TWO) begin
                  fin      = 1'b1;
                  fin_stat = rds_pkg::STAT_UNDER;
                  err_nxt  = 1'b1;
                end else begin
                  state_nxt = rds_pkg::BK_READ;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      rds_pkg::BK_READ: begin
        state_nxt = rds_pkg::BK_EXEC;
      end
      rds_pkg::BK_EXEC: begin
        unique case (op_r)
          rds_pkg::OP_ADD: begin
            top_nxt   = top_r + rdata;
            level_nxt = level_r - LVL_ONE;
            fin       = 1'b1;
          end
          rds_pkg::OP_SUB: begin
            top_nxt   = top_r - rdata;
            level_nxt = level_r - LVL_ONE;
            fin       = 1'b1;
          end
          rds_pkg::OP_MUL: begin
            top_nxt   = top_r * rdata;
            level_nxt = level_r - LVL_ONE;
            fin       = 1'b1;
          end
          rds_pkg::OP_DIV: begin
            if (rdata == 32'd0) begin
              fin      = 1'b1;
              fin_stat = rds_pkg::STAT_DIVZ;
              err_nxt  = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = rds_pkg::BK_DIV;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      rds_pkg::BK_DIV: begin
        if (div_done) begin
          top_nxt   = div_q;
          level_nxt = level_r - LVL_ONE;
          fin       = 1'b1;
        end
      end
      default: state_nxt = rds_pkg::BK_IDLE;
    endcase

    if (fin) begin
      state_nxt = rds_pkg::BK_IDLE;
      outv_nxt  = 1'b1;
      otop_nxt  = (level_nxt != '0) ? top_nxt : 32'd0;
      ostat_nxt = fin_stat;
      odone_nxt = fin_last;
      if (fin_last) begin
        // err_r is still the latch as it stood before this item
        if (fin_stat == rds_pkg::STAT_OK && !err_r && level_nxt == '0) begin
          ostat_nxt = rds_pkg::STAT_EMPTY;
        end
        level_nxt = '0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rds_pkg::BK_IDLE;
      level_r <= '0;
      err_r   <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      err_r   <= err_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    op_r    <= op_nxt;
    last_r  <= last_nxt;
    otop_r  <= otop_nxt;
    ostat_r <= ostat_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid     = outv_r;
  assign out_top_value = otop_r;
  assign out_status    = ostat_r;
  assign out_done_res  = odone_r;

endmodule

@@ src/rpn_digit_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// rpn_digit_stack_evaluator
// Postfix evaluator over single-digit operands, one character per beat.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_char_code, in_last_char
//   out      output     out_valid/out_stall  out_top_value, out_status,
//                                            out_done_res
//
// Digits, ignored characters and underflow, full or latched-error beats finish
// in the take state of the back end. Add/sub/mul and divide by zero pass through
// take, stack RAM read and execute. Divide passes through take, read, execute and
// divider start, the bit-serial divider, then a step to pick up its done.
// A two-entry command queue keeps taking input, until it is full, while the
// back end works or a result waits on out_stall. Reset is synchronous; the stack
// RAM needs no clearing since only entries below the stack level are ever used.
// ----------------------------------------------------------------------------
module rpn_digit_stack_evaluator #(
  parameter int STACK_DEPTH = rds_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_top_value,
  output logic [2:0]         out_status,
  output logic               out_done_res
);

  logic          cmd_valid;
  logic          cmd_ready;
  rds_pkg::cmd_t cmd;

  rds_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  rds_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_status    (out_status),
    .out_done_res  (out_done_res)
  );

endmodule

@@ src/rds_checker.sv @@
// ----------------------------------------------------------------------------
// rds_checker
// Port-level assertions for the RPN digit stack evaluator.
// ----------------------------------------------------------------------------
module rds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_top_value,
  input logic [2:0]         out_status,
  input logic               out_done_res
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_value) &&
      $stable(out_status) && $stable(out_done_res))
    else $error("result beat changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= rds_pkg::STAT_EMPTY)
    else $error("status code out of range");

  // empty-at-end only on the final beat, with a zero answer
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rds_pkg::STAT_EMPTY |-> out_done_res && out_top_value == 0)
    else $error("empty status without final beat or with nonzero top");

  // a full-stack error leaves a digit on top, so top is 0..9
  a_full_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rds_pkg::STAT_FULL |-> out_top_value >= 0 && out_top_value <= 9)
    else $error("stack full reported with a non-digit top");

endmodule

bind rpn_digit_stack_evaluator rds_checker u_rds_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_top_value (out_top_value),
  .out_status    (out_status),
  .out_done_res  (out_done_res)
);

@@ bench/rpn_digit_stack_evaluator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_digit_stack_evaluator_checker
// Watches both channels of the RPN evaluator. Every accepted input beat runs
// through a local stack predictor. Every accepted output beat is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module rpn_digit_stack_evaluator_checker #(
  parameter int STACK_DEPTH = rds_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_top_value,
  input  logic [2:0]         out_status,
  input  logic               out_done_res,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [31:0]      top;
    rds_pkg::status_t status;
    logic             done;
  } stack_result_t;

  logic [31:0]   operand_mem [STACK_DEPTH];
  int            level = 0;
  logic          err_latched = 1'b0;
  stack_result_t expected_results [$];
  int            fails = 0;
  int            pending_n = 0;

  assign fail_count    = fails;
  assign pending_count = pending_n;

  function automatic stack_result_t eval_char(input logic [7:0] c, input logic last);
    stack_result_t    res;
    rds_pkg::status_t st;
    logic             was_err;
    logic [31:0]      t, n, r, ma, mb;
    st      = rds_pkg::STAT_OK;
    was_err = err_latched;
    r       = '0;
    if (!err_latched) begin
      if (c >= rds_pkg::CH_ZERO && c <= rds_pkg::CH_NINE) begin
        if (level >= STACK_DEPTH) begin
          st = rds_pkg::STAT_FULL;
        end else begin
          operand_mem[level] = 32'(c - rds_pkg::CH_ZERO);
          level++;
        end
      end else if (c == rds_pkg::CH_PLUS || c == rds_pkg::CH_MINUS ||
                   c == rds_pkg::CH_STAR || c == rds_pkg::CH_SLASH) begin
        if (level < 2) begin
          st = rds_pkg::STAT_UNDER;
        end else begin
          // T is the top, N the value below it; result is T op N
          t = operand_mem[level-1];
          n = operand_mem[level-2];
          case (c)
            rds_pkg::CH_PLUS:  r = t + n;
            rds_pkg::CH_MINUS: r = t - n;
            rds_pkg::CH_STAR:  r = t * n;
            default: begin
              if (n == 32'd0) begin
                st = rds_pkg::STAT_DIVZ;
              end else begin
                // magnitude divide, sign fixed up after: truncates toward zero
                ma = t[31] ? -t : t;
                mb = n[31] ? -n : n;
                r  = ma / mb;
                if (t[31] != n[31]) r = -r;
              end
            end
          endcase
          if (st == rds_pkg::STAT_OK) begin
            level--;
            operand_mem[level-1] = r;
          end
        end
      end
      if (st != rds_pkg::STAT_OK) err_latched = 1'b1;
    end
    res.top = (level == 0) ? 32'd0 : operand_mem[level-1];
    if (last) begin
      if (st == rds_pkg::STAT_OK && !was_err && level == 0) st = rds_pkg::STAT_EMPTY;
      level       = 0;
      err_latched = 1'b0;
    end
    res.status = st;
    res.done   = last;
    return res;
  endfunction

  always @(posedge clk) begin
    stack_result_t exp_res;
    if (!rst_n) begin
      level       = 0;
      err_latched = 1'b0;
      expected_results.delete();
      pending_n <= 0;
    end else begin
      // results first: a beat accepted at this edge cannot have answered yet
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: top_value %0d status %0d done_res %0b",
                 out_top_value, out_status, out_done_res);
          fails++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_top_value !== exp_res.top) begin
            $error("top_value mismatch: expected %0d, actual %0d",
                   $signed(exp_res.top), out_top_value);
            fails++;
          end
          if (out_status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status, out_status);
            fails++;
          end
          if (out_done_res !== exp_res.done) begin
            $error("done_res mismatch: expected %0b, actual %0b", exp_res.done, out_done_res);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(eval_char(in_char_code, in_last_char));
      pending_n <= expected_results.size();
    end
  end

endmodule

@@ bench/rpn_digit_stack_evaluator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_digit_stack_evaluator_test
// Drives character beats into the RPN evaluator: a directed set of corner
// expressions, then random well-formed expressions, stack overflow runs and
// junk, under rotating sender and receiver throttling. The checker next to
// the block does the prediction; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module rpn_digit_stack_evaluator_test;

  localparam int ITEM_TARGET  = 1050;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code = 8'd0;
  logic               in_last_char = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_top_value;
  logic [2:0]         out_status;
  logic               out_done_res;
  int                 fail_count;
  int                 pending_count;

  int         tx_pct = 0;
  int         rx_pct = 0;
  int         items_sent = 0;
  int         cycle_count = 0;
  logic [7:0] expr_chars [$];

  rpn_digit_stack_evaluator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_last_char  (in_last_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_status    (out_status),
    .out_done_res  (out_done_res)
  );

  rpn_digit_stack_evaluator_checker #(
    .STACK_DEPTH (rds_pkg::STACK_DEPTH_DEF)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_last_char  (in_last_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_status    (out_status),
    .out_done_res  (out_done_res),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] digit_ch(input int d);
    return rds_pkg::CH_ZERO + 8'(d);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return rds_pkg::CH_PLUS;
      1:       return rds_pkg::CH_MINUS;
      2:       return rds_pkg::CH_STAR;
      default: return rds_pkg::CH_SLASH;
    endcase
  endfunction

  // Send the queued expression, last flag on its final character.
  task automatic play_expr();
    for (int i = 0; i < expr_chars.size(); i++) begin
      while ($urandom_range(0, 99) < tx_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_char_code <= expr_chars[i];
      in_last_char <= (i == expr_chars.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      items_sent++;
    end
    expr_chars.delete();
  endtask

  initial begin
    int expr_idx;
    int depth;
    int n_tok;
    int n_extra;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 7 3 - then a space as last: 3 - 7
    expr_chars = '{digit_ch(7), digit_ch(3), rds_pkg::CH_MINUS, rds_pkg::CH_SPACE};
    play_expr();
    // operator on an empty stack, as the last beat
    expr_chars = '{rds_pkg::CH_PLUS};
    play_expr();
    // only ignored codes: empty at end
    expr_chars = '{8'h00, 8'hFF};
    play_expr();
    // divide by zero, then a digit swallowed by the latched error
    expr_chars = '{digit_ch(0), digit_ch(5), rds_pkg::CH_SLASH, digit_ch(9)};
    play_expr();
    // build -1 below, 2^31 on top (8^10 * 2), then divide: min / -1 wraps
    expr_chars = '{digit_ch(1), digit_ch(0), rds_pkg::CH_MINUS, digit_ch(8)};
    repeat (9) begin
      expr_chars.push_back(digit_ch(8));
      expr_chars.push_back(rds_pkg::CH_STAR);
    end
    expr_chars.push_back(digit_ch(2));
    expr_chars.push_back(rds_pkg::CH_STAR);
    expr_chars.push_back(rds_pkg::CH_SLASH);
    play_expr();

    expr_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      case ((expr_idx / 6) % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 60; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 60; end
        default: begin tx_pct = 35; rx_pct = 35; end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          // overflow the stack, then one more op and a trailing space
          n_extra = $urandom_range(1, 3);
          repeat (rds_pkg::STACK_DEPTH_DEF + n_extra)
            expr_chars.push_back(digit_ch($urandom_range(0, 9)));
          expr_chars.push_back(pick_op());
          expr_chars.push_back(rds_pkg::CH_SPACE);
        end
        1, 2: begin
          // junk: any byte, stray ops and digits
          n_tok = $urandom_range(1, 10);
          repeat (n_tok) begin
            case ($urandom_range(0, 3))
              0, 1:    expr_chars.push_back(8'($urandom_range(0, 255)));
              2:       expr_chars.push_back(pick_op());
              default: expr_chars.push_back(digit_ch($urandom_range(0, 9)));
            endcase
          end
        end
        default: begin
          // well formed: ops only when two values are held, reduced to one
          n_tok = $urandom_range(1, 24);
          depth = 0;
          repeat (n_tok) begin
            if ($urandom_range(0, 4) == 0) expr_chars.push_back(rds_pkg::CH_SPACE);
            if (depth < 2 || (depth < 12 && $urandom_range(0, 1) == 0)) begin
              expr_chars.push_back(digit_ch($urandom_range(0, 9)));
              depth++;
            end else begin
              expr_chars.push_back(pick_op());
              depth--;
            end
          end
          while (depth > 1) begin
            expr_chars.push_back(pick_op());
            depth--;
          end
          if ($urandom_range(0, 2) == 0) expr_chars.push_back(rds_pkg::CH_SPACE);
        end
      endcase
      play_expr();
      expr_idx++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rds_pkg.sv
src/rds_ram.sv
src/rds_div.sv
src/rds_front.sv
src/rds_back.sv
src/rpn_digit_stack_evaluator.sv
src/rds_checker.sv
bench/rpn_digit_stack_evaluator_checker.sv
bench/rpn_digit_stack_evaluator_test.sv
